FILE: hdl/blake2b_hash_engine_unit_defines.svh
// Assertion macros used by the BLAKE2b engine top level.
// Depends on nothing; included by files that carry assertions.
`ifndef BLAKE2B_HASH_ENGINE_UNIT_DEFINES_SVH
`define BLAKE2B_HASH_ENGINE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define B2_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define B2_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define B2_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define B2_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/b2_pkg.sv
// Constants and types for the BLAKE2b engine.
// Used by the G-function unit and the top level.
package b2_pkg;
  localparam int unsigned Rounds = 12;
  localparam logic [31:0] PARAM_WORD0 = 32'h0101_0000;

  typedef logic [63:0] word_t;

  localparam word_t IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}};

  // Working-vector indices a, b, c, d for each of the eight G steps.
  localparam logic [3:0] GIDX [8][4] = '{
    '{4'd0, 4'd4, 4'd8, 4'd12}, '{4'd1, 4'd5, 4'd9, 4'd13},
    '{4'd2, 4'd6, 4'd10, 4'd14}, '{4'd3, 4'd7, 4'd11, 4'd15},
    '{4'd0, 4'd5, 4'd10, 4'd15}, '{4'd1, 4'd6, 4'd11, 4'd12},
    '{4'd2, 4'd7, 4'd8, 4'd13}, '{4'd3, 4'd4, 4'd9, 4'd14}};

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } quad_t;

  function automatic word_t ror64(input word_t x, input int unsigned n);
    ror64 = (x >> n) | (x << (64 - n));
  endfunction
endpackage

FILE: hdl/b2_gmix.sv
// Half of the BLAKE2b G function, one add-xor-rotate pass per cycle.
// Depends on b2_pkg.
module b2_gmix import b2_pkg::*; (
  input  logic  clk,
  input  logic  half_sel,
  input  quad_t q_in,
  input  word_t msg,
  output quad_t q_out
);
  quad_t q_nxt;
  quad_t q_r;
  word_t a1, d1, c1;

  always_comb begin
    a1 = q_in.a + q_in.b + msg;
    d1 = ror64(q_in.d ^ a1, half_sel ? 16 : 32);
    c1 = q_in.c + d1;
    q_nxt.a = a1;
    q_nxt.d = d1;
    q_nxt.c = c1;
    q_nxt.b = ror64(q_in.b ^ c1, half_sel ? 63 : 24);
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q_out = q_r;
endmodule

FILE: hdl/blake2b_hash_engine_unit.sv
// BLAKE2b engine top level: byte buffer, counters, sequencer, digest output.
// Depends on b2_pkg, b2_gmix and the assertion macro header.
//
// The engine takes one request when idle and then buffers its bytes one per
// cycle, pausing for any compression, and returns to idle when the request
// is stored and no compression is due. When the buffer is full and more
// bytes arrive, or on a last request, one compression runs: a setup state,
// 12 rounds of eight G steps through the shared half-G unit (two passes and
// a write-back state each), and a state that folds the result. After a
// last request the digest words leave one per accepted output request.
`include "blake2b_hash_engine_unit_defines.svh"
module blake2b_hash_engine_unit import b2_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_digest_length,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_message_bytes,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_word,
  output logic [3:0]  out_valid_bytes,
  output logic        out_last_word
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILL = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_G1   = 3'd3;
  localparam logic [2:0] S_G2   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;
  localparam logic [2:0] S_WB   = 3'd7;

  logic [2:0]  state_r;
  logic [6:0]  len_r;
  word_t       h_r [8];
  word_t       v_r [16];
  word_t       m_r [16];
  word_t       cnt_lo_r, cnt_hi_r;
  logic [7:0]  bcount_r;
  logic [63:0] data_r;
  logic [3:0]  nbytes_r;
  logic [3:0]  bidx_r;
  logic        last_r;
  logic        final_r;
  logic [3:0]  round_r;
  logic [2:0]  gstep_r;
  logic [2:0]  wcount_r;
  logic [6:0]  eff_len;
  logic [3:0]  nwords;
  quad_t       q_in, q_out;
  word_t       msg;
  logic [3:0]  sig_row;
  logic [3:0]  ia, ib, ic, id;
  logic [6:0]  rem_len;
  logic [3:0]  vb;
  word_t       h0_init;

  always_comb begin
    if (len_r == 7'd0) begin
      eff_len = 7'd1;
    end else if (len_r > 7'd64) begin
      eff_len = 7'd64;
    end else begin
      eff_len = len_r;
    end
  end
  assign nwords = 4'((eff_len + 7'd7) >> 3);
  assign h0_init = IV[0] ^ {32'd0, PARAM_WORD0 ^ {25'd0, eff_len}};

  assign sig_row = (round_r >= 4'd10) ? round_r - 4'd10 : round_r;
  assign ia = GIDX[gstep_r][0];
  assign ib = GIDX[gstep_r][1];
  assign ic = GIDX[gstep_r][2];
  assign id = GIDX[gstep_r][3];
  assign q_in = (state_r == S_G1) ? quad_t'{v_r[ia], v_r[ib], v_r[ic], v_r[id]}
                                  : q_out;
  assign msg = m_r[SIGMA[sig_row][{gstep_r, (state_r == S_G2)}]];

  b2_gmix u_gmix (
    .clk      (clk),
    .half_sel (state_r == S_G2),
    .q_in     (q_in),
    .msg      (msg),
    .q_out    (q_out)
  );

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign rem_len = eff_len - {1'b0, wcount_r, 3'd0};
  assign vb = (rem_len > 7'd8) ? 4'd8 : 4'(rem_len);
  always_comb begin
    out_digest_word = h_r[wcount_r];
    for (int k = 0; k < 8; k++) begin
      if (4'(k) >= vb) begin
        out_digest_word[k*8 +: 8] = 8'd0;
      end
    end
  end
  assign out_valid_bytes = vb;
  assign out_last_word = ({1'b0, wcount_r} + 4'd1 == nwords);

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      state_r  <= S_IDLE;
      bcount_r <= 8'd0;
      cnt_lo_r <= '0;
      cnt_hi_r <= '0;
      if (!rst_n) begin
        len_r <= 7'd32;
        h_r[0] <= IV[0] ^ 64'h0101_0020;
      end else begin
        len_r <= cfg_digest_length;
        h_r[0] <= IV[0] ^ {32'd0, PARAM_WORD0 ^ {25'd0, (cfg_digest_length == 7'd0) ? 7'd1 :
                  (cfg_digest_length > 7'd64) ? 7'd64 : cfg_digest_length}};
      end
      for (int i = 1; i < 8; i++) h_r[i] <= IV[i];
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            data_r   <= in_message_bytes;
            nbytes_r <= (in_byte_count > 4'd8) ? 4'd8 : in_byte_count;
            last_r   <= in_last_item;
            bidx_r   <= 4'd0;
            state_r  <= S_FILL;
          end
        end
        S_FILL: begin
          if (bidx_r < nbytes_r && bcount_r == 8'd128) begin
            {cnt_hi_r, cnt_lo_r} <= {cnt_hi_r, cnt_lo_r} + 128'd128;
            final_r <= 1'b0;
            state_r <= S_INIT;
          end else if (bidx_r < nbytes_r) begin
            m_r[bcount_r[6:3]][bcount_r[2:0]*8 +: 8] <= data_r[bidx_r[2:0]*8 +: 8];
            bcount_r <= bcount_r + 8'd1;
            bidx_r   <= bidx_r + 4'd1;
          end else if (last_r) begin
            {cnt_hi_r, cnt_lo_r} <= {cnt_hi_r, cnt_lo_r} + {120'd0, bcount_r};
            for (int j = 0; j < 128; j++) begin
              if (8'(j) >= bcount_r) m_r[j/8][(j%8)*8 +: 8] <= 8'd0;
            end
            final_r <= 1'b1;
            state_r <= S_INIT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_INIT: begin
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
          for (int i = 8; i < 12; i++) v_r[i] <= IV[i-8];
          v_r[12] <= IV[4] ^ cnt_lo_r;
          v_r[13] <= IV[5] ^ cnt_hi_r;
          v_r[14] <= final_r ? ~IV[6] : IV[6];
          v_r[15] <= IV[7];
          round_r <= 4'd0;
          gstep_r <= 3'd0;
          state_r <= S_G1;
        end
        S_G1: state_r <= S_G2;
        S_G2: state_r <= S_WB;
        S_WB: begin
          v_r[ia] <= q_out.a;
          v_r[ib] <= q_out.b;
          v_r[ic] <= q_out.c;
          v_r[id] <= q_out.d;
          gstep_r <= gstep_r + 3'd1;
          if (gstep_r == 3'd7) begin
            round_r <= round_r + 4'd1;
            state_r <= (round_r == 4'(Rounds - 1)) ? S_FIN : S_G1;
          end else begin
            state_r <= S_G1;
          end
        end
        S_FIN: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] ^ v_r[i] ^ v_r[i+8];
          bcount_r <= 8'd0;
          wcount_r <= 3'd0;
          state_r  <= final_r ? S_OUT : S_FILL;
        end
        S_OUT: begin
          if (!out_stall) begin
            wcount_r <= wcount_r + 3'd1;
            if (out_last_word) begin
              h_r[0] <= h0_init;
              for (int i = 1; i < 8; i++) h_r[i] <= IV[i];
              cnt_lo_r <= '0;
              cnt_hi_r <= '0;
              state_r  <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `B2_ASSERT_IMP(a_out_idle_excl, clk, rst_n, out_valid, in_stall)
  `B2_ASSERT_IMP(a_bcount_range, clk, rst_n, 1'b1, bcount_r <= 8'd128)
  `B2_ASSERT_IMP(a_vb_range, clk, rst_n, out_valid, vb != 4'd0)
  `B2_ASSERT_NXT(a_last_to_idle, clk, rst_n,
                 out_valid && !out_stall && out_last_word && !cfg_we, !out_valid)
endmodule

FILE: test/blake2b_digest_checker.sv
// Checker for the BLAKE2b engine: watches the request and digest channels,
// predicts digest words with its own BLAKE2b model and compares them.
// Depends on b2_pkg for the initial chain value.
`timescale 1ns / 100ps
module blake2b_digest_checker import b2_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_digest_length,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [63:0] in_message_bytes,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last_item,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_digest_word,
  input  logic [3:0]  out_valid_bytes,
  input  logic        out_last_word,
  output int          fail_count,
  output int          pending_words,
  output int          digest_count
);
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } digest_word_t;

  localparam logic [3:0] PERM [10][16] = '{
    '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
    '{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
    '{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
    '{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
    '{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
    '{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
    '{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
    '{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
    '{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
    '{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}};

  logic [63:0]  hval [8];
  logic [127:0] total_bytes;
  logic [7:0]   blk [128];
  int           fill;
  int           dlen;
  digest_word_t digest_fifo [$];

  function automatic logic [63:0] rotr(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic int clamp_len(logic [6:0] v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  task automatic reinit();
    for (int i = 0; i < 8; i++) hval[i] = IV[i];
    hval[0] ^= 64'(32'h0101_0000 ^ dlen);
    total_bytes = '0;
    fill = 0;
    for (int i = 0; i < 128; i++) blk[i] = 8'h00;
  endtask

  task automatic compress_block(bit final_blk);
    logic [63:0] m [16];
    logic [63:0] v [16];
    int ga [8], gb [8], gc [8], gd [8];
    ga = '{0, 1, 2, 3, 0, 1, 2, 3};
    gb = '{4, 5, 6, 7, 5, 6, 7, 4};
    gc = '{8, 9, 10, 11, 10, 11, 8, 9};
    gd = '{12, 13, 14, 15, 15, 12, 13, 14};
    for (int i = 0; i < 16; i++)
      for (int j = 0; j < 8; j++) m[i][8*j +: 8] = blk[i*8 + j];
    for (int i = 0; i < 8; i++) begin
      v[i] = hval[i];
      v[i+8] = IV[i];
    end
    v[12] ^= total_bytes[63:0];
    v[13] ^= total_bytes[127:64];
    if (final_blk) v[14] = ~v[14];
    for (int r = 0; r < 12; r++) begin
      for (int g = 0; g < 8; g++) begin
        v[ga[g]] = v[ga[g]] + v[gb[g]] + m[PERM[r%10][2*g]];
        v[gd[g]] = rotr(v[gd[g]] ^ v[ga[g]], 32);
        v[gc[g]] = v[gc[g]] + v[gd[g]];
        v[gb[g]] = rotr(v[gb[g]] ^ v[gc[g]], 24);
        v[ga[g]] = v[ga[g]] + v[gb[g]] + m[PERM[r%10][2*g+1]];
        v[gd[g]] = rotr(v[gd[g]] ^ v[ga[g]], 16);
        v[gc[g]] = v[gc[g]] + v[gd[g]];
        v[gb[g]] = rotr(v[gb[g]] ^ v[gc[g]], 63);
      end
    end
    for (int i = 0; i < 8; i++) hval[i] ^= v[i] ^ v[i+8];
  endtask

  task automatic absorb_request(logic [63:0] data, logic [3:0] cnt, logic last);
    int n;
    int nwords;
    int left;
    digest_word_t dw;
    n = (cnt > 8) ? 8 : cnt;
    for (int i = 0; i < n; i++) begin
      if (fill >= 128) begin
        total_bytes += 128;
        compress_block(1'b0);
        fill = 0;
      end
      blk[fill] = data[8*i +: 8];
      fill++;
    end
    if (!last) return;
    total_bytes += fill;
    for (int i = fill; i < 128; i++) blk[i] = 8'h00;
    compress_block(1'b1);
    nwords = (dlen + 7) / 8;
    for (int k = 0; k < nwords; k++) begin
      left = dlen - 8*k;
      if (left > 8) left = 8;
      dw.word = hval[k];
      if (left < 8) dw.word &= (64'd1 << (8*left)) - 1;
      dw.nbytes = 4'(left);
      dw.last = (k + 1 == nwords);
      digest_fifo.push_back(dw);
    end
    reinit();
  endtask

  always @(posedge clk) begin
    digest_word_t exp_w;
    if (!rst_n) begin
      dlen = 32;
      reinit();
      digest_fifo.delete();
      pending_words = 0;
      fail_count <= 0;
      digest_count <= 0;
    end else begin
      if (cfg_we) begin
        dlen = clamp_len(cfg_digest_length);
        reinit();
      end else if (in_valid && !in_stall) begin
        absorb_request(in_message_bytes, in_byte_count, in_last_item);
      end
      if (out_valid && !out_stall) begin
        digest_count <= digest_count + 1;
        if (digest_fifo.size() == 0) begin
          $display("%0t: unexpected digest word %h", $time, out_digest_word);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = digest_fifo.pop_front();
          if (exp_w.word !== out_digest_word || exp_w.nbytes !== out_valid_bytes ||
              exp_w.last !== out_last_word) begin
            $display("%0t: digest mismatch expected %h/%0d/%0b actual %h/%0d/%0b", $time,
                     exp_w.word, exp_w.nbytes, exp_w.last,
                     out_digest_word, out_valid_bytes, out_last_word);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_words = digest_fifo.size();
    end
  end
endmodule

FILE: test/tb_blake2b_hash_engine_unit.sv
// Testbench top for the BLAKE2b engine: drives message requests, digest
// length writes and output stalls; the checker module scores the digests.
`timescale 1ns / 100ps
module tb_blake2b_hash_engine_unit;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_digest_length = 7'd32;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_message_bytes = '0;
  logic [3:0]  in_byte_count = '0;
  logic        in_last_item = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_digest_word;
  logic [3:0]  out_valid_bytes;
  logic        out_last_word;
  int          fail_count, pending_words, digest_count;
  int          cycle_count = 0;
  int          sent_requests = 0;
  bit          quiet_phase = 1'b0;
  bit          hold_out = 1'b0;

  localparam int CycleLimit = 900000;

  blake2b_hash_engine_unit u_dut (.*);
  blake2b_digest_checker u_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_blake2b_hash_engine_unit: errors");
      $finish;
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (hold_out || quiet_phase) begin
      out_stall <= hold_out;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_request(logic [63:0] data, logic [3:0] cnt, logic last);
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_message_bytes <= data;
    in_byte_count <= cnt;
    in_last_item <= last;
    do @(posedge clk); while (in_stall);
    sent_requests++;
  endtask

  task automatic drain_and_write(logic [6:0] len);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_digest_length <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_message(int nreq, bit odd_counts);
    logic [3:0] c;
    for (int i = 0; i < nreq; i++) begin
      c = odd_counts ? 4'($urandom_range(0, 15)) : 4'd8;
      send_request({$urandom, $urandom}, c, i == nreq - 1);
    end
  endtask

  initial begin
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: empty message, extreme data, byte counts above eight, full blocks.
    send_request('0, 4'd0, 1'b1);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
    send_request(64'h0123_4567_89AB_CDEF, 4'd15, 1'b1);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 1'b0);
    send_request('0, 4'd1, 1'b1);
    for (int i = 0; i < 16; i++) send_request({$urandom, $urandom}, 4'd8, i == 15);
    drain_and_write(7'd64);
    send_request(64'hA5A5_5A5A_0F0F_F0F0, 4'd3, 1'b1);
    drain_and_write(7'd0);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
    drain_and_write(7'd127);
    send_request(64'h1, 4'd8, 1'b1);
    // A message left unfinished before a length write must be dropped.
    send_request(64'h55, 4'd8, 1'b0);
    drain_and_write(7'd1);
    send_request(64'h77, 4'd2, 1'b1);
    // Long output hold-off while requests keep coming.
    drain_and_write(7'd64);
    hold_out = 1'b1;
    fork
      begin
        repeat (1500) @(posedge clk);
        hold_out = 1'b0;
      end
      for (int m = 0; m < 3; m++) send_message(2, 1'b1);
    join
    for (int p = 0; p < 5; p++) begin
      drain_and_write(7'($urandom_range(0, 127)));
      while (sent_requests < 55 * (p + 1)) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
        if (p == 4) quiet_phase = 1'b1;
        send_message(n, $urandom_range(0, 2) != 0);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Covered %0d requests, %0d digest words, lengths 1..64 incl. clamped writes.",
             sent_requests, digest_count);
    if (fail_count == 0) begin
      $display("tb_blake2b_hash_engine_unit: clean");
    end else begin
      $display("tb_blake2b_hash_engine_unit: errors");
    end
    $finish;
  end
endmodule
